// ----- rtl/assert_macros.svh -----
// Assertion macros used by the RTL controller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/ccl_pkg.sv -----
// ----------------------------------------------------------------------------
// ccl_pkg
// Shared types and constants for the largest connected component block.
// ----------------------------------------------------------------------------
package ccl_pkg;

  localparam int MaxV = 64;
  localparam int VW   = $clog2(MaxV);
  localparam int CW   = VW + 1;

  typedef logic [VW-1:0] vtx_t;
  typedef logic [CW-1:0] cnt_t;

  localparam logic [1:0] VERDICT_IN_LARGEST = 2'd0;
  localparam logic [1:0] VERDICT_ALL_SINGLE = 2'd1;
  localparam logic [1:0] VERDICT_GO_TARGET  = 2'd2;
  localparam logic [1:0] VERDICT_INVALID    = 2'd3;

  localparam logic [0:0] OP_EDGE  = 1'b0;
  localparam logic [0:0] OP_QUERY = 1'b1;

  localparam int REG_VERTEX_COUNT = 0;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture input transaction
    logic edge_rd;    // read both endpoint rows into registers
    logic add_edge;   // write both symmetric bits
    logic q_init;     // clear visited, counters
    logic root_chk;   // test root vertex, maybe start component
    logic root_adv;   // advance root
    logic pop;        // pop stack top into a register
    logic row_rd;     // read adjacency row of popped vertex
    logic scan;       // scan one neighbour
    logic fin;        // compute verdict from recorded stats
    logic fin_adv;    // advance target search
    logic out_load;   // load output register
  } ccl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_query;
    logic edge_ok;
    logic root_done;   // all roots scanned
    logic root_new;    // current root unvisited
    logic stack_empty;
    logic scan_last;   // current neighbour is last
    logic fin_done;    // verdict ready
  } ccl_sts_t;

endpackage

// ----- rtl/ccl_if.sv -----
// ----------------------------------------------------------------------------
// ccl_in_if / ccl_out_if
// Valid/ready channels for input items and results.
// ----------------------------------------------------------------------------
interface ccl_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [5:0] from_vertex;
  logic [5:0] to_vertex;
  logic [5:0] query_vertex;
  modport source (output valid, op, from_vertex, to_vertex, query_vertex, input ready);
  modport sink   (input valid, op, from_vertex, to_vertex, query_vertex, output ready);
endinterface

interface ccl_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] verdict;
  logic [5:0] target_vertex;
  logic [6:0] largest_size;
  logic [6:0] component_count;
  modport source (output valid, verdict, target_vertex, largest_size, component_count,
                  input ready);
  modport sink   (input valid, verdict, target_vertex, largest_size, component_count,
                  output ready);
endinterface

// ----- rtl/ccl_ctrl.sv -----
// ----------------------------------------------------------------------------
// ccl_ctrl
// Sequencer for edge inserts, component walk and verdict search.
// ----------------------------------------------------------------------------
module ccl_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             out_busy,
  input  ccl_pkg::ccl_sts_t sts,
  output ccl_pkg::ccl_cmd_t cmd
);
  import ccl_pkg::*;
  `include "assert_macros.svh"

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_DEC   = 10'b00_0000_0010,
    S_ROOT  = 10'b00_0000_0100,
    S_POP   = 10'b00_0000_1000,
    S_SCAN  = 10'b00_0001_0000,
    S_FIN   = 10'b00_0010_0000,
    S_OUT   = 10'b00_0100_0000,
    S_INIT  = 10'b00_1000_0000,
    S_EDGE  = 10'b01_0000_0000,
    S_ROW   = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (sts.is_query) begin
          cmd.q_init = 1'b1;
          state_nxt  = S_INIT;
        end else if (sts.edge_ok) begin
          cmd.edge_rd = 1'b1;
          state_nxt   = S_EDGE;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_EDGE: begin
        cmd.add_edge = 1'b1;
        state_nxt    = S_IDLE;
      end
      S_INIT: state_nxt = S_ROOT;
      S_ROOT: begin
        if (sts.root_done) begin
          state_nxt = S_FIN;
        end else if (sts.root_new) begin
          cmd.root_chk = 1'b1;
          state_nxt    = S_POP;
        end else begin
          cmd.root_adv = 1'b1;
        end
      end
      S_POP: begin
        if (sts.stack_empty) begin
          cmd.root_adv = 1'b1;
          state_nxt    = S_ROOT;
        end else begin
          cmd.pop   = 1'b1;
          state_nxt = S_ROW;
        end
      end
      S_ROW: begin
        cmd.row_rd = 1'b1;
        state_nxt  = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) state_nxt = S_POP;
      end
      S_FIN: begin
        if (sts.fin_done) begin
          if (!out_busy) begin
            cmd.out_load = 1'b1;
            state_nxt    = S_OUT;
          end
        end else begin
          cmd.fin_adv = 1'b1;
        end
        cmd.fin = 1'b1;
      end
      S_OUT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  `ASSERT_IMPL(a_onehot, clk, rst_n, 1'b1, $onehot(state_r))
  `ASSERT_NEXT(a_load_dec, clk, rst_n, cmd.load, state_r == S_DEC)
  `ASSERT_IMPL(a_out_free, clk, rst_n, cmd.out_load, !out_busy)
endmodule

// ----- rtl/ccl_dp.sv -----
// ----------------------------------------------------------------------------
// ccl_dp
// Adjacency matrix, visited mask, DFS stack and component statistics.
// ----------------------------------------------------------------------------
module ccl_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  ccl_pkg::ccl_cmd_t cmd,
  output ccl_pkg::ccl_sts_t sts,
  input  logic [6:0]        vcount,
  input  logic              in_op,
  input  ccl_pkg::vtx_t     in_from,
  input  ccl_pkg::vtx_t     in_to,
  input  ccl_pkg::vtx_t     in_query,
  output logic [1:0]        res_verdict,
  output ccl_pkg::vtx_t     res_target,
  output ccl_pkg::cnt_t     res_largest,
  output ccl_pkg::cnt_t     res_count
);
  import ccl_pkg::*;

  // adjacency: per-row valid bits (reset), rows read into registers
  logic [MaxV-1:0] adj_r [MaxV];
  logic [MaxV-1:0] row_ok_r;
  logic [MaxV-1:0] visited_r;

  vtx_t stack_mem [MaxV];
  cnt_t size_mem  [MaxV];
  vtx_t start_mem [MaxV];
  cnt_t lab_size_r; // size of query vertex component

  logic          op_r;
  vtx_t          a_r, b_r, q_r;
  cnt_t          n;
  cnt_t          root_r, sp_r, nb_r, comp_r, size_r, largest_r, fi_r;
  logic [MaxV-1:0] row_r;
  logic [MaxV-1:0] ra_r, rb_r;
  vtx_t          top_r;
  logic          q_in_comp_r, found_r;
  vtx_t          target_r;
  vtx_t          fin_start_r;
  cnt_t          fin_size_r;
  logic          fin_rd_ok_r;
  logic          comp_pend_r;

  assign n = (vcount > 7'(MaxV)) ? CW'(MaxV) : CW'(vcount);

  logic nb_hit;
  assign nb_hit = row_r[nb_r[VW-1:0]] && !visited_r[nb_r[VW-1:0]];

  assign sts.is_query    = op_r == OP_QUERY;
  assign sts.edge_ok     = (CW'(a_r) < n) && (CW'(b_r) < n);
  assign sts.root_done   = root_r >= n;
  assign sts.root_new    = !visited_r[root_r[VW-1:0]];
  assign sts.stack_empty = (sp_r == '0) && !cmd.root_chk;
  assign sts.scan_last   = (nb_r + 1'b1) >= n;
  assign sts.fin_done    = fin_rd_ok_r && (found_r || fi_r >= comp_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_ok_r  <= '0;
      visited_r <= '0;
    end else begin
      if (cmd.add_edge) begin
        row_ok_r[a_r] <= 1'b1;
        row_ok_r[b_r] <= 1'b1;
      end
      if (cmd.q_init) visited_r <= '0;
      if (cmd.root_chk) visited_r[root_r[VW-1:0]] <= 1'b1;
      if (cmd.scan && nb_hit) visited_r[nb_r[VW-1:0]] <= 1'b1;
    end
  end

  // adjacency rows: both endpoint rows read in the same cycle, written back in the next
  always_ff @(posedge clk) begin
    if (cmd.edge_rd) begin
      ra_r <= row_ok_r[a_r] ? adj_r[a_r] : '0;
      rb_r <= row_ok_r[b_r] ? adj_r[b_r] : '0;
    end
    if (cmd.add_edge) begin
      adj_r[a_r] <= ra_r | (MaxV'(1) << b_r);
      if (a_r != b_r) adj_r[b_r] <= rb_r | (MaxV'(1) << a_r);
    end
    if (cmd.row_rd) row_r <= row_ok_r[top_r] ? adj_r[top_r] : '0;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_op; a_r <= in_from; b_r <= in_to; q_r <= in_query;
    end
    if (cmd.q_init) begin
      root_r <= '0; comp_r <= '0; largest_r <= '0; sp_r <= '0;
      q_in_comp_r <= 1'b0; lab_size_r <= '0;
    end
    if (cmd.root_chk) begin
      stack_mem[0] <= root_r[VW-1:0];
      sp_r         <= CW'(1);
      size_r       <= CW'(1);
      q_in_comp_r  <= (root_r[VW-1:0] == q_r);
    end
    if (cmd.pop) begin
      top_r <= stack_mem[sp_r[VW-1:0] - VW'(1)];
      sp_r  <= sp_r - 1'b1;
    end
    if (cmd.row_rd) nb_r <= '0;
    if (cmd.scan) begin
      nb_r <= nb_r + 1'b1;
      if (nb_hit) begin
        stack_mem[sp_r[VW-1:0]] <= nb_r[VW-1:0];
        sp_r   <= sp_r + 1'b1;
        size_r <= size_r + 1'b1;
        if (nb_r[VW-1:0] == q_r) q_in_comp_r <= 1'b1;
      end
    end
    if (cmd.root_adv) root_r <= root_r + 1'b1;
    // component end: record stats
    if (cmd.root_adv && sts.stack_empty && visited_r[root_r[VW-1:0]] && comp_pend_r) begin
      size_mem[comp_r[VW-1:0]]  <= size_r;
      start_mem[comp_r[VW-1:0]] <= root_r[VW-1:0];
      comp_r <= comp_r + 1'b1;
      if (size_r > largest_r) largest_r <= size_r;
      if (q_in_comp_r) lab_size_r <= size_r;
    end
  end

  // a component is open between root_chk and its closing root_adv
  always_ff @(posedge clk) begin
    if (!rst_n) comp_pend_r <= 1'b0;
    else if (cmd.root_chk) comp_pend_r <= 1'b1;
    else if (cmd.root_adv) comp_pend_r <= 1'b0;
  end

  // target search: scan recorded components in order, each read registered and compared before the next is read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_rd_ok_r <= 1'b0;
    end else if (!cmd.fin) begin
      fin_rd_ok_r <= 1'b0;
      fi_r <= '0; found_r <= 1'b0; target_r <= '0;
    end else begin
      fin_size_r  <= size_mem[fi_r[VW-1:0]];
      fin_start_r <= start_mem[fi_r[VW-1:0]];
      if (!fin_rd_ok_r) begin
        fin_rd_ok_r <= 1'b1;
      end else if (cmd.fin_adv) begin
        if (fin_size_r == largest_r) begin
          found_r  <= 1'b1;
          target_r <= fin_start_r;
        end else begin
          fi_r <= fi_r + 1'b1;
          fin_rd_ok_r <= 1'b0;
        end
      end
    end
  end

  always_comb begin
    res_largest = largest_r;
    res_count   = comp_r;
    res_target  = '0;
    if (CW'(q_r) >= n)               res_verdict = VERDICT_INVALID;
    else if (lab_size_r == largest_r) res_verdict = (largest_r != CW'(1)) ?
                                        VERDICT_IN_LARGEST : VERDICT_ALL_SINGLE;
    else begin
      res_verdict = VERDICT_GO_TARGET;
      res_target  = target_r;
    end
  end
endmodule

// ----- rtl/connected_components_largest_core.sv -----
// ----------------------------------------------------------------------------
// connected_components_largest_core
// Largest connected component over an adjacency bit matrix.
// ----------------------------------------------------------------------------
// channel | dir | payload
// in_     | in  | op, from_vertex, to_vertex, query_vertex
// out_    | out | verdict, target_vertex, largest_size, component_count
// cfg_    | in  | vertex_count at address 0
//
// Edge insert: capture, decode with both row reads, then row write; an
// ignored edge ends after decode. A query with n vertices and c components
// pops, reads the row of and scans each vertex one neighbour a cycle, then
// runs the per-component search.
// Reset is synchronous and clears the matrix at once through row valid bits.
// The result waits in an output register; a stalled output only holds a query
// at its last step.
module connected_components_largest_core (
  input  logic       clk,
  input  logic       rst_n,
  ccl_in_if.sink     in_ch,
  ccl_out_if.source  out_ch,
  input  logic       cfg_psel,
  input  logic       cfg_penable,
  input  logic       cfg_pwrite,
  input  logic [0:0] cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic       cfg_pready
);
  import ccl_pkg::*;

  logic [6:0] vcount_r;
  ccl_cmd_t cmd;
  ccl_sts_t sts;
  logic [1:0] r_verdict;
  vtx_t r_target;
  cnt_t r_largest, r_count;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == 1'(REG_VERTEX_COUNT)) ? {25'd0, vcount_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) vcount_r <= 7'd64;
    else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == 1'(REG_VERTEX_COUNT))
      vcount_r <= cfg_pwdata[6:0];
  end

  ccl_ctrl u_ctrl (
    .clk, .rst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_busy(out_ch.valid && !out_ch.ready), .sts, .cmd
  );

  ccl_dp u_dp (
    .clk, .rst_n, .cmd, .sts, .vcount(vcount_r),
    .in_op(in_ch.op), .in_from(in_ch.from_vertex), .in_to(in_ch.to_vertex),
    .in_query(in_ch.query_vertex), .res_verdict(r_verdict),
    .res_target(r_target), .res_largest(r_largest), .res_count(r_count)
  );

  logic ov_r;
  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (cmd.out_load) ov_r <= 1'b1;
    else if (out_ch.ready) ov_r <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_ch.verdict         <= r_verdict;
      out_ch.target_vertex   <= r_target;
      out_ch.largest_size    <= r_largest;
      out_ch.component_count <= r_count;
    end
  end
  assign out_ch.valid = ov_r;
endmodule

// ----- tb/ccl_scoreboard.sv -----
// ----------------------------------------------------------------------------
// ccl_scoreboard
// Watches the edge/query and result channels and the register port. It keeps
// its own copy of the adjacency matrix and vertex count, predicts each query
// result and compares every result transaction field by field.
// ----------------------------------------------------------------------------
module ccl_scoreboard
  import ccl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  ccl_in_if           in_mon,
  ccl_out_if          out_mon,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [0:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          fails,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0] verdict;
    vtx_t       target_vertex;
    cnt_t       largest_size;
    cnt_t       component_count;
  } ccl_result_t;

  logic [MaxV-1:0] adj_rows [MaxV];
  logic [6:0]      vcount;
  ccl_result_t     answers_due [$];

  function automatic int live_vertices();
    return (vcount > MaxV) ? MaxV : int'(vcount);
  endfunction

  // Flood each component from its lowest vertex; symmetric rows make the
  // closure equal to the depth-first walk.
  function automatic ccl_result_t solve_query(input vtx_t q);
    int              n;
    int              count;
    int              largest;
    int              q_size;
    int              sz;
    int              sizes [MaxV];
    int              starts [MaxV];
    logic [MaxV-1:0] mask;
    logic [MaxV-1:0] seen;
    logic [MaxV-1:0] comp;
    logic [MaxV-1:0] prev;
    ccl_result_t     r;
    n = live_vertices();
    mask = (n == MaxV) ? '1 : ((64'd1 << n) - 64'd1);
    seen = '0;
    count = 0;
    largest = 0;
    q_size = 0;
    for (int i = 0; i < n; i++) begin
      if (!seen[i]) begin
        comp = '0;
        comp[i] = 1'b1;
        do begin
          prev = comp;
          for (int v = 0; v < n; v++)
            if (prev[v]) comp |= adj_rows[v] & mask;
        end while (comp != prev);
        sz = $countones(comp);
        seen |= comp;
        sizes[count] = sz;
        starts[count] = i;
        if (comp[q]) q_size = sz;
        if (sz > largest) largest = sz;
        count++;
      end
    end
    r.target_vertex = '0;
    if (q >= n) begin
      r.verdict = VERDICT_INVALID;
    end else if (q_size == largest) begin
      r.verdict = (largest != 1) ? VERDICT_IN_LARGEST : VERDICT_ALL_SINGLE;
    end else begin
      r.verdict = VERDICT_GO_TARGET;
      for (int i = count - 1; i >= 0; i--)
        if (sizes[i] == largest) r.target_vertex = vtx_t'(starts[i]);
    end
    r.largest_size = cnt_t'(largest);
    r.component_count = cnt_t'(count);
    return r;
  endfunction

  task automatic note_mismatch(input string field, input int exp_v, input int act_v);
    if (fails < 10)
      $display("mismatch %s: expected %0d, got %0d at %0t", field, exp_v, act_v, $realtime);
    fails++;
  endtask

  always @(posedge clk) begin
    ccl_result_t exp_r;
    if (!rst_n) begin
      for (int i = 0; i < MaxV; i++) adj_rows[i] = '0;
      vcount <= 7'd64;
      answers_due.delete();
      fails = 0;
      pending <= 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
          && cfg_paddr == 1'(REG_VERTEX_COUNT))
        vcount <= cfg_pwdata[6:0];
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.op == OP_QUERY) begin
          answers_due.push_back(solve_query(in_mon.query_vertex));
        end else if (in_mon.from_vertex < live_vertices()
                     && in_mon.to_vertex < live_vertices()) begin
          adj_rows[in_mon.from_vertex][in_mon.to_vertex] = 1'b1;
          adj_rows[in_mon.to_vertex][in_mon.from_vertex] = 1'b1;
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        if (answers_due.size() == 0) begin
          if (fails < 10) $display("result transaction with nothing expected at %0t", $realtime);
          fails++;
        end else begin
          exp_r = answers_due.pop_front();
          if (out_mon.verdict !== exp_r.verdict)
            note_mismatch("verdict", exp_r.verdict, out_mon.verdict);
          if (out_mon.target_vertex !== exp_r.target_vertex)
            note_mismatch("target_vertex", exp_r.target_vertex, out_mon.target_vertex);
          if (out_mon.largest_size !== exp_r.largest_size)
            note_mismatch("largest_size", exp_r.largest_size, out_mon.largest_size);
          if (out_mon.component_count !== exp_r.component_count)
            note_mismatch("component_count", exp_r.component_count,
                          out_mon.component_count);
        end
      end
      pending <= answers_due.size();
    end
  end

endmodule

// ----- tb/connected_components_largest_core_test.sv -----
// ----------------------------------------------------------------------------
// connected_components_largest_core_test
// Drives edge inserts and component queries over several vertex counts, with
// random gaps and result stalls, and reports the scoreboard's verdict.
// ----------------------------------------------------------------------------
module connected_components_largest_core_test;
  import ccl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QuietLimit = 40000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [0:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  int          fails;
  int          pending;
  int          quiet_cycles = 0;
  int          stall_left = 0;
  bit          no_idle = 1'b0;

  ccl_in_if  in_ch ();
  ccl_out_if out_ch ();

  connected_components_largest_core dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  ccl_scoreboard scoreboard (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_pready(cfg_pready),
    .fails(fails), .pending(pending)
  );

  always #10 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.op = OP_EDGE;
    in_ch.from_vertex = '0;
    in_ch.to_vertex = '0;
    in_ch.query_vertex = '0;
    out_ch.ready = 1'b0;
  end

  // result side back-pressure: a fresh stall drawn after every transaction
  always @(posedge clk) begin
    int draw;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left <= 0;
    end else if (out_ch.valid && out_ch.ready) begin
      draw = no_idle ? 0 : $urandom_range(0, 8);
      stall_left <= draw;
      out_ch.ready <= (draw == 0);
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= (stall_left == 1);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
          || (cfg_psel && cfg_penable))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic send_item(input logic op, input int a, input int b, input int q);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= op;
    in_ch.from_vertex <= 6'(a);
    in_ch.to_vertex <= 6'(b);
    in_ch.query_vertex <= 6'(q);
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // let the block drain, including a trailing edge write with no result
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic set_vertex_count(input int value);
    drain();
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= 1'(REG_VERTEX_COUNT * 4);
    cfg_pwdata <= 32'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // mostly in-range edges with a few strays; queries rarer on big graphs
  task automatic random_phase(input int n, input int items);
    int span;
    int q_odds;
    span = (n < 1) ? 1 : ((n > MaxV) ? MaxV : n);
    q_odds = (span > 32) ? 24 : 6;
    for (int k = 0; k < items; k++) begin
      if (k == items / 2) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      if ($urandom_range(0, q_odds - 1) == 0)
        send_item(OP_QUERY, $urandom_range(0, 63), $urandom_range(0, 63),
                  ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63)
                                              : $urandom_range(0, span - 1));
      else if ($urandom_range(0, 9) == 0)
        send_item(OP_EDGE, $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 63));
      else
        send_item(OP_EDGE, $urandom_range(0, span - 1), $urandom_range(0, span - 1),
                  $urandom_range(0, 63));
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty graph, corner vertices, self loop, targets
    send_item(OP_QUERY, 0, 0, 0);
    send_item(OP_QUERY, 63, 63, 63);
    send_item(OP_EDGE, 63, 63, 0);
    send_item(OP_QUERY, 0, 0, 63);
    send_item(OP_EDGE, 0, 63, 0);
    send_item(OP_QUERY, 0, 0, 63);
    send_item(OP_QUERY, 0, 0, 5);
    send_item(OP_EDGE, 5, 6, 0);
    send_item(OP_EDGE, 6, 7, 0);
    send_item(OP_QUERY, 0, 0, 0);
    send_item(OP_QUERY, 0, 0, 7);
    set_vertex_count(2);
    send_item(OP_EDGE, 1, 40, 0);
    send_item(OP_QUERY, 0, 0, 0);
    send_item(OP_QUERY, 0, 0, 1);
    send_item(OP_QUERY, 0, 0, 2);
    set_vertex_count(1);
    send_item(OP_QUERY, 0, 0, 0);
    send_item(OP_EDGE, 0, 1, 0);
    send_item(OP_QUERY, 0, 0, 1);
    set_vertex_count(0);
    send_item(OP_EDGE, 0, 0, 0);
    send_item(OP_QUERY, 0, 0, 0);
    set_vertex_count(100);
    send_item(OP_QUERY, 0, 0, 63);

    random_phase(100, 90);
    set_vertex_count(5);
    random_phase(5, 90);
    no_idle = 1'b1;
    set_vertex_count(12);
    random_phase(12, 90);
    no_idle = 1'b0;
    set_vertex_count(2);
    random_phase(2, 60);
    set_vertex_count(1);
    random_phase(1, 40);
    set_vertex_count(0);
    random_phase(0, 30);
    for (int p = 0; p < 3; p++) begin
      set_vertex_count($urandom_range(3, 20));
      random_phase(20, 80);
    end
    set_vertex_count($urandom_range(65, 127));
    random_phase(64, 60);
    set_vertex_count(64);
    random_phase(64, 60);

    drain();
    if (fails == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/ccl_pkg.sv
rtl/ccl_if.sv
rtl/ccl_ctrl.sv
rtl/ccl_dp.sv
rtl/connected_components_largest_core.sv
tb/ccl_scoreboard.sv
tb/connected_components_largest_core_test.sv
